FILE: src/omwsl_pkg.sv
// ----------------------------------------------------------------------------
// omwsl_pkg: shared definitions for the omni wheel mixer with slew limit
// Fixed-point constants, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package omwsl_pkg;

  // Q-format of all velocities and drives
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned CFG_W     = 15;

  // sqrt2 in Q2.14, rounded
  localparam logic signed [DATA_W-1:0] SQRT2_Q = 16'sd23170;

  // Rounding offset: half of 3 * 2^FRAC_BITS
  localparam logic [31:0] ROUND_HALF = 32'(3 * (1 << (FRAC_BITS - 1)));

  // Divide by three through a reciprocal: exact for quotient inputs below 2^19
  localparam int unsigned T_W         = 18;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP = 20'(((1 << RECIP_SHIFT) + 2) / 3);

  // Register reset values
  localparam logic [CFG_W-1:0] ROT_GAIN_RST  = 15'd6857;
  localparam logic [CFG_W-1:0] SLEW_STEP_RST = 15'd819;

  // Register indexes (byte address bit 2)
  localparam logic REG_ROT_GAIN  = 1'b0;
  localparam logic REG_SLEW_STEP = 1'b1;

  // Wheel indexes
  typedef logic [1:0] wheel_t;
  localparam wheel_t WHEEL_FL = 2'd0;
  localparam wheel_t WHEEL_FR = 2'd1;
  localparam wheel_t WHEEL_BL = 2'd2;
  localparam wheel_t WHEEL_BR = 2'd3;

  // Program counter
  typedef logic [2:0] upc_t;

  // Hold condition of a microcode step: stay on the step while it is true
  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_WAIT_IN  = 2'd1,
    COND_WAIT_OUT = 2'd2
  } omwsl_cond_e;

  // Datapath control of one step
  typedef struct packed {
    logic   load;
    logic   sum_en;
    wheel_t sum_wheel;
    logic   div_en;
    logic   slew_en;
    wheel_t slew_wheel;
    logic   publish;
  } omwsl_ctrl_t;

  typedef struct packed {
    omwsl_cond_e cond;
    omwsl_ctrl_t ctrl;
  } omwsl_uword_t;

  // Term signs per wheel: {side negated, rotation negated}
  function automatic logic [1:0] wheel_signs(input wheel_t wheel);
    logic [1:0] s;
    unique case (wheel)
      WHEEL_FL: s = 2'b00;
      WHEEL_FR: s = 2'b11;
      WHEEL_BL: s = 2'b10;
      WHEEL_BR: s = 2'b01;
      default:  s = 2'b00;
    endcase
    return s;
  endfunction

  function automatic omwsl_ctrl_t mk_ctrl(input logic load, input logic sum_en,
                                          input wheel_t sum_wheel, input logic div_en,
                                          input logic slew_en, input wheel_t slew_wheel,
                                          input logic publish);
    omwsl_ctrl_t c;
    c.load       = load;
    c.sum_en     = sum_en;
    c.sum_wheel  = sum_wheel;
    c.div_en     = div_en;
    c.slew_en    = slew_en;
    c.slew_wheel = slew_wheel;
    c.publish    = publish;
    return c;
  endfunction

  // Microcode program: sum, divide and slew run as a three-deep pipeline
  // over the four wheels.
  function automatic omwsl_uword_t uc_rom(input upc_t upc);
    omwsl_uword_t w;
    unique case (upc)
      3'd0: w = '{COND_WAIT_IN,
                  mk_ctrl(1'b1, 1'b0, WHEEL_FL, 1'b0, 1'b0, WHEEL_FL, 1'b0)};
      3'd1: w = '{COND_NONE,
                  mk_ctrl(1'b0, 1'b1, WHEEL_FL, 1'b0, 1'b0, WHEEL_FL, 1'b0)};
      3'd2: w = '{COND_NONE,
                  mk_ctrl(1'b0, 1'b1, WHEEL_FR, 1'b1, 1'b0, WHEEL_FL, 1'b0)};
      3'd3: w = '{COND_NONE,
                  mk_ctrl(1'b0, 1'b1, WHEEL_BL, 1'b1, 1'b1, WHEEL_FL, 1'b0)};
      3'd4: w = '{COND_NONE,
                  mk_ctrl(1'b0, 1'b1, WHEEL_BR, 1'b1, 1'b1, WHEEL_FR, 1'b0)};
      3'd5: w = '{COND_NONE,
                  mk_ctrl(1'b0, 1'b0, WHEEL_FL, 1'b1, 1'b1, WHEEL_BL, 1'b0)};
      3'd6: w = '{COND_NONE,
                  mk_ctrl(1'b0, 1'b0, WHEEL_FL, 1'b0, 1'b1, WHEEL_BR, 1'b0)};
      3'd7: w = '{COND_WAIT_OUT,
                  mk_ctrl(1'b0, 1'b0, WHEEL_FL, 1'b0, 1'b0, WHEEL_FL, 1'b1)};
      default: w = '{COND_NONE,
                     mk_ctrl(1'b0, 1'b0, WHEEL_FL, 1'b0, 1'b0, WHEEL_FL, 1'b0)};
    endcase
    return w;
  endfunction

endpackage

FILE: src/omwsl_datapath.sv
// ----------------------------------------------------------------------------
// omwsl_datapath: mixer and slew limiter datapath
// Products, per-wheel target sum, divide by three with saturation, slew
// update of the stored drives and the output word register.
// ----------------------------------------------------------------------------
module omwsl_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  omwsl_pkg::omwsl_ctrl_t                 ctrl_i,
  input  logic signed [omwsl_pkg::DATA_W-1:0]    vel_x_i,
  input  logic signed [omwsl_pkg::DATA_W-1:0]    vel_y_i,
  input  logic signed [omwsl_pkg::DATA_W-1:0]    yaw_rate_i,
  input  logic        [omwsl_pkg::CFG_W-1:0]     rot_gain_i,
  input  logic        [omwsl_pkg::CFG_W-1:0]     slew_step_i,
  output logic signed [omwsl_pkg::DATA_W-1:0]    drive_fl_o,
  output logic signed [omwsl_pkg::DATA_W-1:0]    drive_fr_o,
  output logic signed [omwsl_pkg::DATA_W-1:0]    drive_bl_o,
  output logic signed [omwsl_pkg::DATA_W-1:0]    drive_br_o
);

  localparam int unsigned PROD_W = 31;
  localparam int unsigned SUM_W  = 34;
  localparam int unsigned DIV_W  = omwsl_pkg::T_W + omwsl_pkg::RECIP_W;
  localparam int unsigned GAP_W  = omwsl_pkg::DATA_W + 1;

  // Operand registers
  logic signed [omwsl_pkg::DATA_W-1:0] vy_q;
  logic signed [PROD_W-1:0]            side_q, side_d;
  logic signed [PROD_W-1:0]            rot_q, rot_d;

  // Pipeline registers
  logic [omwsl_pkg::T_W-1:0]           t_q, t_d;
  logic                                neg_q, neg_d;
  logic signed [omwsl_pkg::DATA_W-1:0] tgt_q, tgt_d;

  // Drive state and output word
  logic signed [omwsl_pkg::DATA_W-1:0] drive_q [4];
  logic signed [omwsl_pkg::DATA_W-1:0] drive_d;
  logic signed [omwsl_pkg::DATA_W-1:0] out_q [4];

  // Form products straight from the accepted word
  always_comb begin
    side_d = PROD_W'(vel_x_i) * PROD_W'(omwsl_pkg::SQRT2_Q);
    rot_d  = PROD_W'(yaw_rate_i) * $signed(PROD_W'({1'b0, rot_gain_i}));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      vy_q   <= vel_y_i;
      side_q <= side_d;
      rot_q  <= rot_d;
    end
  end

  // Sum the wheel target, take magnitude with rounding, scale down
  logic signed [SUM_W-1:0] lin_s, side_s, rot_s, num_s, pos_r, neg_r, mag_s;
  logic [1:0]              signs;

  always_comb begin
    signs  = omwsl_pkg::wheel_signs(ctrl_i.sum_wheel);
    lin_s  = SUM_W'($signed({vy_q, {omwsl_pkg::FRAC_BITS{1'b0}}}));
    side_s = signs[1] ? -SUM_W'(side_q) : SUM_W'(side_q);
    rot_s  = signs[0] ? -SUM_W'(rot_q) : SUM_W'(rot_q);
    num_s  = lin_s + side_s + rot_s;
    pos_r  = lin_s + side_s + rot_s + $signed(SUM_W'(omwsl_pkg::ROUND_HALF));
    neg_r  = $signed(SUM_W'(omwsl_pkg::ROUND_HALF)) - lin_s - side_s - rot_s;
    neg_d  = num_s[SUM_W-1];
    mag_s  = neg_d ? neg_r : pos_r;
    t_d    = mag_s[omwsl_pkg::FRAC_BITS +: omwsl_pkg::T_W];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      t_q   <= t_d;
      neg_q <= neg_d;
    end
  end

  // Divide by three through the reciprocal, then saturate
  logic [DIV_W-1:0]          prod;
  logic [omwsl_pkg::T_W-1:0] quo, quo_neg;

  always_comb begin
    prod    = DIV_W'(t_q) * DIV_W'(omwsl_pkg::RECIP);
    quo     = prod[omwsl_pkg::RECIP_SHIFT +: omwsl_pkg::T_W];
    quo_neg = '0 - quo;
    if (neg_q) begin
      if (quo > omwsl_pkg::T_W'(32768)) begin
        tgt_d = {1'b1, {(omwsl_pkg::DATA_W-1){1'b0}}};
      end else begin
        tgt_d = quo_neg[omwsl_pkg::DATA_W-1:0];
      end
    end else begin
      if (quo > omwsl_pkg::T_W'(32767)) begin
        tgt_d = {1'b0, {(omwsl_pkg::DATA_W-1){1'b1}}};
      end else begin
        tgt_d = quo[omwsl_pkg::DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_en) begin
      tgt_q <= tgt_d;
    end
  end

  // Move the drive one step toward its target when the gap exceeds the step
  logic signed [GAP_W-1:0] cur_s, gap_s, step_s, up_s, dn_s;

  always_comb begin
    cur_s  = GAP_W'(drive_q[ctrl_i.slew_wheel]);
    step_s = $signed(GAP_W'({1'b0, slew_step_i}));
    gap_s  = GAP_W'(tgt_q) - cur_s;
    up_s   = cur_s + step_s;
    dn_s   = cur_s - step_s;
    if (gap_s > step_s) begin
      drive_d = up_s[omwsl_pkg::DATA_W-1:0];
    end else if (gap_s < -step_s) begin
      drive_d = dn_s[omwsl_pkg::DATA_W-1:0];
    end else begin
      drive_d = cur_s[omwsl_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        drive_q[i] <= '0;
      end
    end else if (ctrl_i.slew_en) begin
      drive_q[ctrl_i.slew_wheel] <= drive_d;
    end
  end

  // Capture the output word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.publish) begin
      for (int i = 0; i < 4; i++) begin
        out_q[i] <= drive_q[i];
      end
    end
  end

  assign drive_fl_o = out_q[omwsl_pkg::WHEEL_FL];
  assign drive_fr_o = out_q[omwsl_pkg::WHEEL_FR];
  assign drive_bl_o = out_q[omwsl_pkg::WHEEL_BL];
  assign drive_br_o = out_q[omwsl_pkg::WHEEL_BR];

endmodule

FILE: src/omni_wheel_mixer_slew_limit_unit.sv
// ----------------------------------------------------------------------------
// omni_wheel_mixer_slew_limit_unit: mecanum mixer with per-tick slew limit
// Microcoded sequencer, configuration registers and handshake control around
// the mixer datapath.
// ----------------------------------------------------------------------------
// Flow: the input word is taken on the first step of the 8-step microcode
//   program and the output word is registered on its last step; one word per
//   pass of the program, which holds on its last step while the output is stalled.
// Reset: drives clear to zero, registers return to rotation_gain 6857 and
//   slew_step 819, the sequencer waits for input, no output is valid.
module omni_wheel_mixer_slew_limit_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [omwsl_pkg::DATA_W-1:0] vel_x_i,
  input  logic signed [omwsl_pkg::DATA_W-1:0] vel_y_i,
  input  logic signed [omwsl_pkg::DATA_W-1:0] yaw_rate_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [omwsl_pkg::DATA_W-1:0] drive_front_left_o,
  output logic signed [omwsl_pkg::DATA_W-1:0] drive_front_right_o,
  output logic signed [omwsl_pkg::DATA_W-1:0] drive_back_left_o,
  output logic signed [omwsl_pkg::DATA_W-1:0] drive_back_right_o
);

  logic [omwsl_pkg::CFG_W-1:0] rot_gain_q;
  logic [omwsl_pkg::CFG_W-1:0] slew_step_q;
  logic                        cfg_wr;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_gain_q  <= omwsl_pkg::ROT_GAIN_RST;
      slew_step_q <= omwsl_pkg::SLEW_STEP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        omwsl_pkg::REG_ROT_GAIN:  rot_gain_q  <= pwdata[omwsl_pkg::CFG_W-1:0];
        omwsl_pkg::REG_SLEW_STEP: slew_step_q <= pwdata[omwsl_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      omwsl_pkg::REG_ROT_GAIN:  prdata = 32'(rot_gain_q);
      omwsl_pkg::REG_SLEW_STEP: prdata = 32'(slew_step_q);
      default:                  prdata = '0;
    endcase
  end

  // Microcode sequencer
  omwsl_pkg::upc_t         upc_q, upc_d;
  omwsl_pkg::omwsl_uword_t uword;
  omwsl_pkg::omwsl_ctrl_t  ctrl;
  logic                    hold;
  logic                    out_valid_q, out_valid_d;

  assign uword = omwsl_pkg::uc_rom(upc_q);

  always_comb begin
    case (uword.cond)
      omwsl_pkg::COND_WAIT_IN:  hold = !in_valid_i;
      omwsl_pkg::COND_WAIT_OUT: hold = out_valid_q && out_stall_i;
      default:                  hold = 1'b0;
    endcase
    upc_d = hold ? upc_q : upc_q + omwsl_pkg::upc_t'(1);
  end

  // Gate the control word with the step's hold condition
  always_comb begin
    ctrl         = uword.ctrl;
    ctrl.load    = uword.ctrl.load && !hold;
    ctrl.publish = uword.ctrl.publish && !hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
    end else begin
      upc_q <= upc_d;
    end
  end

  // Input is taken only on the load step
  assign in_stall_o = !uword.ctrl.load;

  // Output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  omwsl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .yaw_rate_i  (yaw_rate_i),
    .rot_gain_i  (rot_gain_q),
    .slew_step_i (slew_step_q),
    .drive_fl_o  (drive_front_left_o),
    .drive_fr_o  (drive_front_right_o),
    .drive_bl_o  (drive_back_left_o),
    .drive_br_o  (drive_back_right_o)
  );

endmodule
